@@ design/fdsm_pkg.sv @@
package fdsm_pkg;

  // Drive population
  localparam int unsigned DRIVE_COUNT = 4;
  localparam int unsigned DRV_EXT_W   = 3;  // drive number widened to cover up to 8 drives
  localparam int unsigned DRV_W       = (DRIVE_COUNT > 1) ? $clog2(DRIVE_COUNT) : 1;

  // Field widths
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned DRV_F_W = 2;
  localparam int unsigned FSEL_W  = 3;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned SPT_W   = 8;
  localparam int unsigned FLAG_W  = 7;
  localparam int unsigned TRK_W   = 7;
  localparam int unsigned SIDE_W  = 2;
  localparam int unsigned ID_W    = 8;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_W      = 25;
  localparam int unsigned OUT_DATA_W = 32;

  // Divider: 9-bit dividend, one bit per cycle
  localparam int unsigned DIV_DVD_W = ID_W + 1;
  localparam int unsigned DIV_CNT_W = 4;

  // Flag bit positions
  localparam int unsigned FLG_PRESENT = 0;
  localparam int unsigned FLG_DISK    = 1;
  localparam int unsigned FLG_MOTOR   = 2;
  localparam int unsigned FLG_READY   = 3;
  localparam int unsigned FLG_TRACK0  = 4;
  localparam int unsigned FLG_WPROT   = 5;
  localparam int unsigned FLG_INDEX   = 6;
  localparam logic [FSEL_W-1:0] FSEL_NONE = 3'd7;

  // Geometry
  localparam logic [TRK_W-1:0]  LIM_SS   = 7'd42;
  localparam logic [TRK_W-1:0]  LIM_DS   = 7'd83;
  localparam logic [SIDE_W-1:0] SIDES_SS = 2'd1;
  localparam logic [SIDE_W-1:0] SIDES_DS = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET_FLAG  = 3'd0,
    ACT_SET_READY = 3'd1,
    ACT_SEEK      = 3'd2,
    ACT_GEOMETRY  = 3'd3,
    ACT_NEXT_ID   = 3'd4,
    ACT_QUERY     = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DIV  = 2'd2,
    ST_SEND = 2'd3
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ design/fdsm_div.sv @@
// Restoring remainder unit, one dividend bit per cycle.
module fdsm_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [fdsm_pkg::DIV_DVD_W-1:0]   dividend_i,
  input  logic [fdsm_pkg::SPT_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic [fdsm_pkg::ID_W-1:0]        rem_o
);

  logic                           busy_q, busy_d;
  logic [fdsm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [fdsm_pkg::DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [fdsm_pkg::ID_W-1:0]      rem_q, rem_d;
  logic [fdsm_pkg::DIV_DVD_W-1:0] trial;
  logic [fdsm_pkg::DIV_DVD_W-1:0] rem_next;

  assign trial    = {rem_q, dvd_q[fdsm_pkg::DIV_DVD_W-1]};
  assign rem_next = (trial >= {1'b0, divisor_i}) ? (trial - {1'b0, divisor_i}) : trial;
  assign done_o   = busy_q && (cnt_q == fdsm_pkg::DIV_CNT_W'(1));
  assign rem_o    = rem_next[fdsm_pkg::ID_W-1:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = fdsm_pkg::DIV_CNT_W'(fdsm_pkg::DIV_DVD_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - fdsm_pkg::DIV_CNT_W'(1);
      dvd_d = {dvd_q[fdsm_pkg::DIV_DVD_W-2:0], 1'b0};
      rem_d = rem_next[fdsm_pkg::ID_W-1:0];
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

endmodule

@@ design/fdsm_dp.sv @@
// Datapath: request register, per-drive state, action logic, result register.
module fdsm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fdsm_pkg::cmd_t                      cmd_i,
  output fdsm_pkg::sts_t                      sts_o,
  input  logic [fdsm_pkg::IN_DATA_W-1:0]      req_data_i,
  input  logic [fdsm_pkg::ACT_W-1:0]          req_action_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic [fdsm_pkg::OUT_DATA_W-1:0]     res_data_o
);

  // Request register
  logic [fdsm_pkg::IN_DATA_W-1:0] data_q;
  logic [fdsm_pkg::ACT_W-1:0]     act_q;

  logic [fdsm_pkg::DRV_F_W-1:0]   f_drive;
  logic [fdsm_pkg::FSEL_W-1:0]    f_fsel;
  logic                           f_level;
  logic                           f_gated;
  logic [fdsm_pkg::STEP_W-1:0]    f_step;
  logic                           f_geom;
  logic [fdsm_pkg::SPT_W-1:0]     f_spt;

  assign f_drive = data_q[1:0];
  assign f_fsel  = data_q[4:2];
  assign f_level = data_q[5];
  assign f_gated = data_q[6];
  assign f_step  = data_q[14:7];
  assign f_geom  = data_q[15];
  assign f_spt   = data_q[23:16];

  logic [fdsm_pkg::DRV_EXT_W-1:0] drv_ext;
  logic [fdsm_pkg::DRV_W-1:0]     idx;
  logic                           drive_ok;

  assign drv_ext  = {{(fdsm_pkg::DRV_EXT_W-fdsm_pkg::DRV_F_W){1'b0}}, f_drive};
  assign idx      = drv_ext[fdsm_pkg::DRV_W-1:0];
  // One extra bit so a full set of eight drives still compares correctly
  assign drive_ok = {1'b0, drv_ext} <
                    (fdsm_pkg::DRV_EXT_W+1)'(fdsm_pkg::DRIVE_COUNT);

  // Per-drive state
  logic [fdsm_pkg::FLAG_W-1:0] flag_q  [fdsm_pkg::DRIVE_COUNT];
  logic [fdsm_pkg::TRK_W-1:0]  trk_q   [fdsm_pkg::DRIVE_COUNT];
  logic [fdsm_pkg::TRK_W-1:0]  lim_q   [fdsm_pkg::DRIVE_COUNT];
  logic [fdsm_pkg::SIDE_W-1:0] sides_q [fdsm_pkg::DRIVE_COUNT];
  logic [fdsm_pkg::ID_W-1:0]   cnt_q   [fdsm_pkg::DRIVE_COUNT];

  logic [fdsm_pkg::FLAG_W-1:0] flg_c, flg_n;
  logic [fdsm_pkg::TRK_W-1:0]  trk_c, trk_n, lim_c, lim_n;
  logic [fdsm_pkg::SIDE_W-1:0] sides_c, sides_n;
  logic [fdsm_pkg::ID_W-1:0]   cnt_c, cnt_n;
  logic                        notify_n;
  logic [fdsm_pkg::ID_W-1:0]   sid_n;

  assign flg_c   = flag_q[idx];
  assign trk_c   = trk_q[idx];
  assign lim_c   = lim_q[idx];
  assign sides_c = sides_q[idx];
  assign cnt_c   = cnt_q[idx];

  // Seek target, clamped to 0..limit-1 (0 with no limit)
  logic [fdsm_pkg::STEP_W-1:0] delta;
  logic signed [9:0]           seek_sum;
  logic [fdsm_pkg::TRK_W-1:0]  seek_t;

  assign delta    = (act_q == fdsm_pkg::ACT_SEEK) ? f_step : '0;
  assign seek_sum = $signed({3'b000, trk_c}) + $signed({{2{delta[7]}}, delta});

  always_comb begin
    if (seek_sum < 0) begin
      seek_t = '0;
    end else if (seek_sum[8:0] >= {2'b00, lim_c}) begin
      seek_t = (lim_c != '0) ? (lim_c - fdsm_pkg::TRK_W'(1)) : '0;
    end else begin
      seek_t = seek_sum[fdsm_pkg::TRK_W-1:0];
    end
  end

  logic spt_zero;
  assign spt_zero = (f_spt == '0);

  always_comb begin
    flg_n    = flg_c;
    trk_n    = trk_c;
    lim_n    = lim_c;
    sides_n  = sides_c;
    cnt_n    = cnt_c;
    notify_n = 1'b0;
    sid_n    = '0;
    case (act_q)
      fdsm_pkg::ACT_SET_FLAG: begin
        if (f_fsel != fdsm_pkg::FSEL_NONE) begin
          flg_n[f_fsel] = f_level;
          if (f_fsel == fdsm_pkg::FSEL_W'(fdsm_pkg::FLG_DISK)) begin
            trk_n                       = seek_t;
            flg_n[fdsm_pkg::FLG_TRACK0] = (seek_t == '0);
            notify_n                    = flg_n[fdsm_pkg::FLG_PRESENT];
          end
        end
      end
      fdsm_pkg::ACT_SET_READY: begin
        if (f_gated && !(flg_c[fdsm_pkg::FLG_PRESENT] && flg_c[fdsm_pkg::FLG_DISK] &&
                         flg_c[fdsm_pkg::FLG_MOTOR])) begin
          flg_n[fdsm_pkg::FLG_READY] = 1'b0;
        end else begin
          flg_n[fdsm_pkg::FLG_READY] = f_level;
        end
      end
      fdsm_pkg::ACT_SEEK: begin
        trk_n                       = seek_t;
        flg_n[fdsm_pkg::FLG_TRACK0] = (seek_t == '0);
        notify_n                    = flg_c[fdsm_pkg::FLG_PRESENT];
      end
      fdsm_pkg::ACT_GEOMETRY: begin
        lim_n                       = f_geom ? fdsm_pkg::LIM_DS : fdsm_pkg::LIM_SS;
        sides_n                     = f_geom ? fdsm_pkg::SIDES_DS : fdsm_pkg::SIDES_SS;
        cnt_n                       = '0;
        trk_n                       = '0;
        flg_n[fdsm_pkg::FLG_TRACK0] = 1'b1;
      end
      fdsm_pkg::ACT_NEXT_ID: begin
        flg_n[fdsm_pkg::FLG_INDEX] = spt_zero || (cnt_c == (f_spt - fdsm_pkg::SPT_W'(1)));
        sid_n                      = cnt_c;
        if (spt_zero) begin
          cnt_n = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Counter wrap goes through the serial remainder unit
  logic                      div_start;
  logic                      div_done;
  logic [fdsm_pkg::ID_W-1:0] div_rem;

  assign sts_o.need_div = drive_ok && (act_q == fdsm_pkg::ACT_NEXT_ID) && !spt_zero;
  assign div_start      = cmd_i.exec && sts_o.need_div;
  assign sts_o.div_done = div_done;

  fdsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({1'b0, cnt_c} + fdsm_pkg::DIV_DVD_W'(1)),
    .divisor_i  (f_spt),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fdsm_pkg::DRIVE_COUNT; i++) begin
        flag_q[i]  <= '0;
        trk_q[i]   <= '0;
        lim_q[i]   <= '0;
        sides_q[i] <= '0;
        cnt_q[i]   <= '0;
      end
    end else begin
      if (cmd_i.exec && drive_ok) begin
        flag_q[idx]  <= flg_n;
        trk_q[idx]   <= trk_n;
        lim_q[idx]   <= lim_n;
        sides_q[idx] <= sides_n;
        cnt_q[idx]   <= cnt_n;
      end else if (div_done) begin
        cnt_q[idx] <= div_rem;
      end
    end
  end

  // Payload-only registers
  logic                      notify_q;
  logic [fdsm_pkg::ID_W-1:0] sid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      data_q <= req_data_i;
      act_q  <= req_action_i;
    end
    if (cmd_i.exec) begin
      notify_q <= drive_ok && notify_n;
      sid_q    <= drive_ok ? sid_n : '0;
    end
  end

  // Result register
  logic                       out_valid_q, out_valid_d;
  logic [fdsm_pkg::OUT_W-1:0] out_q;
  logic [fdsm_pkg::OUT_W-1:0] res_n;
  logic                       present;

  assign present = flg_c[fdsm_pkg::FLG_PRESENT];

  always_comb begin
    if (!drive_ok) begin
      res_n                       = '0;
      res_n[fdsm_pkg::FLG_WPROT]  = 1'b1;
    end else begin
      res_n = {notify_q, sid_q, sides_c, trk_c,
               flg_c[fdsm_pkg::FLG_INDEX],
               present ? flg_c[fdsm_pkg::FLG_WPROT] : 1'b1,
               present && flg_c[fdsm_pkg::FLG_TRACK0],
               flg_c[fdsm_pkg::FLG_READY],
               flg_c[fdsm_pkg::FLG_MOTOR],
               flg_c[fdsm_pkg::FLG_DISK],
               present};
    end
  end

  assign sts_o.out_free = !out_valid_q || res_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= res_n;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_data_o  = {{(fdsm_pkg::OUT_DATA_W-fdsm_pkg::OUT_W){1'b0}}, out_q};

endmodule

@@ design/fdsm_ctrl.sv @@
// Sequencer: take request, apply it, wait for the counter wrap, hand off result.
module fdsm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  fdsm_pkg::sts_t sts_i,
  output fdsm_pkg::cmd_t cmd_o
);

  fdsm_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fdsm_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = fdsm_pkg::ST_EXEC;
        end
      end
      fdsm_pkg::ST_EXEC: begin
        state_d = sts_i.need_div ? fdsm_pkg::ST_DIV : fdsm_pkg::ST_SEND;
      end
      fdsm_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = fdsm_pkg::ST_SEND;
        end
      end
      fdsm_pkg::ST_SEND: begin
        if (sts_i.out_free) begin
          state_d = fdsm_pkg::ST_IDLE;
        end
      end
      default: state_d = fdsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.load    = 1'b0;
    case (state_q)
      fdsm_pkg::ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      fdsm_pkg::ST_EXEC: cmd_o.exec = 1'b1;
      fdsm_pkg::ST_DIV: begin
      end
      fdsm_pkg::ST_SEND: cmd_o.load = sts_i.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdsm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/floppy_drive_status_model.sv @@
// Sequence: a request is accepted in idle, applied in exec and loaded into the output
//   register in send; next id with a nonzero sector count passes first through the
//   one-bit-per-cycle remainder unit (9 steps) in div. A request is taken only in idle,
//   even while the previous result waits in the output register; send waits until it drains.
// Reset: rst_ni asynchronous, active low; clears every drive's flags, track,
//   limit, side count and id counter, and empties the output register.
module floppy_drive_status_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] drive, [4:2] flag_select, [5] level, [6] ready_gated,
  // [14:7] step (signed), [15] geometry, [23:16] sectors_per_track
  input  logic [23:0] s_axis_tdata_i,
  // [2:0] action
  input  logic [2:0]  s_axis_tuser_i,
  // Result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] drive_present, [1] disk_present, [2] motor_on, [3] ready_res,
  // [4] at_track_zero, [5] write_protected, [6] index_pulse, [13:7] track,
  // [15:14] sides, [23:16] sector_id, [24] seek_notify, [31:25] zero
  output logic [31:0] m_axis_tdata_o
);

  // Controller and datapath talk only through these two bundles.
  fdsm_pkg::cmd_t cmd;
  fdsm_pkg::sts_t sts;

  // Controller: one request in flight; a request is taken only in idle.
  fdsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: per-drive state, action logic, sector counter wrap,
  // and the output register that decouples the result side.
  fdsm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_data_i   (s_axis_tdata_i),
    .req_action_i (s_axis_tuser_i),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_data_o   (m_axis_tdata_o)
  );

endmodule
